// ===== design/trial_division_prime_test_defines.svh =====
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define TDPT_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tdpt check failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define TDPT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tdpt check failed");

`endif

// ===== design/tdpt_pkg.sv =====
`timescale 1ns / 1ps

package tdpt_pkg;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture a new item and restart the divisor
      logic div_init;    // clear the remainder and reload the dividend shifter
      logic div_step;    // one restoring division step
      logic next_div;    // advance the divisor and its square
      logic out_load;    // move the finished item into the result register
      logic prime_flag;  // verdict to store with out_load
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic not_candidate;  // negative, zero or one
      logic small_prime;    // two or three
      logic sq_over;        // divisor squared exceeds the value
      logic rem_next_zero;  // remainder after the current step is zero
   } sts_type;

endpackage

// ===== design/tdpt_req_if.sv =====
`timescale 1ns / 1ps

interface tdpt_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] value;
   logic                  last_item;

   modport source (output valid, output value, output last_item, input ready);
   modport sink (input valid, input value, input last_item, output ready);
endinterface

// ===== design/tdpt_rsp_if.sv =====
`timescale 1ns / 1ps

interface tdpt_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] value_out;
   logic                  is_prime;
   logic                  last_out;

   modport source (output valid, output value_out, output is_prime, output last_out,
                   input ready);
   modport sink (input valid, input value_out, input is_prime, input last_out,
                 output ready);
endinterface

// ===== design/tdpt_datapath.sv =====
`timescale 1ns / 1ps

module tdpt_datapath import tdpt_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic [DATA_WIDTH-1:0] req_value,
   input  logic                  req_last_item,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic [DATA_WIDTH-1:0] rsp_value_out,
   output logic                  rsp_is_prime,
   output logic                  rsp_last_out
);
   localparam int SQ_W = DATA_WIDTH + 1;

   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic                  last_ff, last_in;
   logic [DATA_WIDTH-1:0] div_ff, div_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] sh_ff, sh_in;
   logic [DATA_WIDTH-1:0] value_out_ff, value_out_in;
   logic                  is_prime_ff, is_prime_in;
   logic                  last_out_ff, last_out_in;

   logic [SQ_W-1:0]       trial;
   logic [SQ_W-1:0]       diff;
   logic [DATA_WIDTH-1:0] rem_next;

   // One restoring step: bring in the next dividend bit, subtract if it fits.
   always_comb begin
      trial    = {rem_ff, sh_ff[DATA_WIDTH-1]};
      diff     = trial - {1'b0, div_ff};
      rem_next = (trial >= {1'b0, div_ff}) ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
   end

   always_comb begin
      sts.not_candidate = val_ff[DATA_WIDTH-1] || (val_ff <= DATA_WIDTH'(1));
      sts.small_prime   = (val_ff == DATA_WIDTH'(2)) || (val_ff == DATA_WIDTH'(3));
      sts.sq_over       = sq_ff > {1'b0, val_ff};
      sts.rem_next_zero = (rem_next == '0);
   end

   always_comb begin
      val_in       = val_ff;
      last_in      = last_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      sh_in        = sh_ff;
      value_out_in = value_out_ff;
      is_prime_in  = is_prime_ff;
      last_out_in  = last_out_ff;
      if (cmd.load) begin
         val_in  = req_value;
         last_in = req_last_item;
         div_in  = DATA_WIDTH'(2);
         sq_in   = SQ_W'(4);
      end
      if (cmd.div_init) begin
         rem_in = '0;
         sh_in  = val_ff;
      end
      if (cmd.div_step) begin
         rem_in = rem_next;
         sh_in  = {sh_ff[DATA_WIDTH-2:0], 1'b0};
      end
      // (d + 1)^2 = d^2 + 2d + 1, so the square needs only an adder.
      if (cmd.next_div) begin
         div_in = div_ff + DATA_WIDTH'(1);
         sq_in  = sq_ff + {div_ff, 1'b0} + SQ_W'(1);
      end
      if (cmd.out_load) begin
         value_out_in = val_ff;
         is_prime_in  = cmd.prime_flag;
         last_out_in  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      last_ff      <= last_in;
      div_ff       <= div_in;
      sq_ff        <= sq_in;
      rem_ff       <= rem_in;
      sh_ff        <= sh_in;
      value_out_ff <= value_out_in;
      is_prime_ff  <= is_prime_in;
      last_out_ff  <= last_out_in;
   end

   assign rsp_value_out = value_out_ff;
   assign rsp_is_prime  = is_prime_ff;
   assign rsp_last_out  = last_out_ff;
endmodule

// ===== design/tdpt_ctrl.sv =====
`timescale 1ns / 1ps

module tdpt_ctrl import tdpt_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam int CNT_W = $clog2(DATA_WIDTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             prime_ff, prime_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      prime_in  = prime_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.not_candidate) begin
               prime_in = 1'b0;
               state_in = ST_FINISH;
            end else if (sts.small_prime || sts.sq_over) begin
               prime_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.div_init = 1'b1;
               cnt_in       = CNT_W'(DATA_WIDTH - 1);
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if (sts.rem_next_zero) begin
                  prime_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  cmd.next_div = 1'b1;
                  state_in     = ST_CHECK;
               end
            end
         end
         ST_FINISH: begin
            // The previous result must be gone before this one replaces it.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      cmd.prime_flag = prime_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== design/trial_division_prime_test.sv =====
// Flow: after a request transfer the controller checks the value; negative values and values
// of 3 or less finish at once, and otherwise each trial divisor runs a full restoring division
// until a factor is found or the divisor squared exceeds the value.
// Throughput: one item at a time; the next request can be taken in the cycle after the result
// is loaded, and a held result stalls only the next one.
// Reset (synchronous, active high) clears the controller state and the result valid flag.
`timescale 1ns / 1ps

`include "trial_division_prime_test_defines.svh"

module trial_division_prime_test import tdpt_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   tdpt_req_if.sink  req_ch,
   tdpt_rsp_if.source rsp_ch
);
   cmd_type cmd;
   sts_type sts;

   tdpt_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tdpt_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .req_value     (req_ch.value),
      .req_last_item (req_ch.last_item),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_value_out (rsp_ch.value_out),
      .rsp_is_prime  (rsp_ch.is_prime),
      .rsp_last_out  (rsp_ch.last_out)
   );

   `TDPT_ASSERT_NEXT(a_one_in_flight, req_ch.valid && req_ch.ready, !req_ch.ready)
   `TDPT_ASSERT_SAME(a_no_overwrite, cmd.out_load, !rsp_ch.valid || rsp_ch.ready)
   `TDPT_ASSERT_NEXT(a_load_shows, cmd.out_load, rsp_ch.valid)
   `TDPT_ASSERT_SAME(a_prime_positive, rsp_ch.valid && rsp_ch.is_prime,
                     $signed(rsp_ch.value_out) > $signed(DATA_WIDTH'(1)))
endmodule

// ===== test/tb_trial_division_prime_test.sv =====
`timescale 1ns / 1ps

module tb_trial_division_prime_test;

   localparam int W = 32;
   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 40;
   localparam longint CYCLE_LIMIT = 12_000_000;

   typedef struct {
      logic [W-1:0] value;
      logic         last_item;
   } number_type;

   typedef struct {
      logic [W-1:0] value_out;
      logic         is_prime;
      logic         last_out;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tdpt_req_if #(.DATA_WIDTH(W)) req_ch ();
   tdpt_rsp_if #(.DATA_WIDTH(W)) rsp_ch ();

   trial_division_prime_test #(.DATA_WIDTH(W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   number_type  numbers_to_send[$];
   verdict_type verdicts_due[$];

   int     errors = 0;
   int     numbers_queued = 0;
   int     numbers_sent = 0;
   int     verdicts_seen = 0;
   int     primes_seen = 0;
   int     send_gap = 0;
   int     send_calm = 0;
   int     take_stall = 0;
   int     take_calm = 0;
   longint cycles = 0;

   // Trial division over the value taken as a signed number.
   function automatic logic prime_verdict(input logic [W-1:0] v);
      longint unsigned u;
      longint unsigned d;
      if (v[W-1]) return 1'b0;
      u = 64'(v);
      if (u <= 1) return 1'b0;
      if (u == 2 || u == 3) return 1'b1;
      for (d = 2; d * d <= u; d++) begin
         if (u % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Mostly short pauses, a few long ones, with calm stretches of none at all.
   function automatic int pause_len(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
         calm = $urandom_range(8, 24);
         return 0;
      end
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 300);
   endfunction

   // Random values are kept cheap to test: small or medium numbers, negatives,
   // and large numbers forced to have a small factor.
   function automatic logic [W-1:0] random_value();
      int           sel;
      int unsigned  p;
      logic [W-1:0] v;
      int unsigned  factors[10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
      sel = $urandom_range(0, 99);
      v = $urandom();
      if (sel < 30) begin
         v = $urandom_range(0, 2000);
      end else if (sel < 45) begin
         v = $urandom_range(2001, 200000);
      end else if (sel < 65) begin
         v[W-1] = 1'b1;
      end else begin
         v[W-1] = 1'b0;
         p = factors[$urandom_range(0, 9)];
         v = v - (v % p);
         if (v < 2 * p) v = 2 * p;
      end
      return v;
   endfunction

   task automatic queue_number(input logic [W-1:0] v, input logic last);
      number_type n;
      n.value = v;
      n.last_item = last;
      numbers_to_send.push_back(n);
      numbers_queued++;
   endtask

   task automatic report_mismatch(input string field, input logic [W-1:0] got,
                                  input logic [W-1:0] want);
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, field, got, want);
      errors++;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      req_ch.last_item = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   // Driver: offers the next pending number once the previous one transferred.
   always @(posedge clock) begin : drive
      number_type  n;
      verdict_type v;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            v.value_out = req_ch.value;
            v.is_prime = prime_verdict(req_ch.value);
            v.last_out = req_ch.last_item;
            verdicts_due.push_back(v);
            numbers_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0 || numbers_to_send.size() == 0) begin
               req_ch.valid <= 1'b0;
               if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
               n = numbers_to_send.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.value <= n.value;
               req_ch.last_item <= n.last_item;
               send_gap <= pause_len(send_calm);
            end
         end
      end
   end

   // Monitor: checks each result transfer and stalls the result channel at random.
   always @(posedge clock) begin : watch
      verdict_type v;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_stall <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
               report_mismatch("unexpected result", rsp_ch.value_out, '0);
            end else begin
               v = verdicts_due.pop_front();
               if (rsp_ch.value_out !== v.value_out)
                  report_mismatch("value_out", rsp_ch.value_out, v.value_out);
               if (rsp_ch.is_prime !== v.is_prime)
                  report_mismatch("is_prime", W'(rsp_ch.is_prime), W'(v.is_prime));
               if (rsp_ch.last_out !== v.last_out)
                  report_mismatch("last_out", W'(rsp_ch.last_out), W'(v.last_out));
               if (v.is_prime) primes_seen++;
            end
         end
         if (take_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            take_stall <= take_stall - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) take_stall <= pause_len(take_calm);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  verdicts_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      // Directed part: the edges of the field, boundaries of the divisor bound,
      // and the small values that bypass the search.
      queue_number(32'd0, 1'b0);
      queue_number(32'd1, 1'b0);
      queue_number(32'd2, 1'b0);
      queue_number(32'd3, 1'b0);
      queue_number(32'd4, 1'b1);
      queue_number(32'd5, 1'b0);
      queue_number(32'd9, 1'b0);
      queue_number(32'd25, 1'b0);
      queue_number(32'd49, 1'b1);
      queue_number(32'hFFFF_FFFF, 1'b0);
      queue_number(32'h8000_0000, 1'b1);
      queue_number(32'h8000_0001, 1'b0);
      queue_number(32'h7FFF_FFFE, 1'b0);
      queue_number(32'h4000_0000, 1'b0);
      queue_number(32'd97, 1'b0);
      queue_number(32'd121, 1'b1);
      queue_number(32'd7919, 1'b0);
      queue_number(32'd65537, 1'b0);
      queue_number(32'd999983, 1'b0);
      queue_number(32'd1022117, 1'b1);
      queue_number(32'h7FFF_FFFF, 1'b1);
      repeat (80) queue_number(random_value(), $urandom_range(0, 7) == 0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Every queued number must come back as a result transfer.
      while (verdicts_seen < numbers_queued)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d numbers tested (negatives, zero, small, large and max), %0d results",
               numbers_sent, verdicts_seen);
      $display("%0d primes flagged, %0d mismatches", primes_seen, errors);
      if (errors == 0 && verdicts_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== trial_division_prime_test.f =====
+incdir+design
design/tdpt_pkg.sv
design/tdpt_req_if.sv
design/tdpt_rsp_if.sv
design/tdpt_datapath.sv
design/tdpt_ctrl.sv
design/trial_division_prime_test.sv
test/tb_trial_division_prime_test.sv
